/* rtl/core/mncc_pkg.sv */
// Shared constants and types for the masked normalized cross-correlation block.
// No dependencies; used by mncc_front, mncc_back and the top level.
package mncc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH     = 2;

    localparam int FIELD_W   = 16;   // width of a sample port field
    localparam int NCC_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int ACNT_W    = 25;
    localparam int FRAC_BITS = 30;   // Q1.30 result
    localparam int OUT_DATA_W = 64;  // ncc_value + active_count padded to bytes

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FLAT  = 2'd2
    } status_t;

endpackage

/* rtl/core/mncc_queue.sv */
// Small result-record queue between the accumulating front end and the back end.
// Depends on nothing outside this file.
module mncc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [W-1:0]                 din,
    input  logic                         pop,
    output logic [W-1:0]                 dout,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

/* rtl/core/mncc_front.sv */
// Front end: takes voxel transfers, forms squares and cross products, accumulates masked sums.
// Uses mncc_pkg; pushes one sum record per image into mncc_queue.
module mncc_front #(
    parameter int SAMPLE_BITS = mncc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = mncc_pkg::COUNT_BITS_DEF,
    parameter int DEPTH       = mncc_pkg::QUEUE_DEPTH,
    parameter int REC_W       = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mncc_pkg::FIELD_W-1:0] ref_sample,
    input  logic [mncc_pkg::FIELD_W-1:0] warped_sample,
    input  logic                         in_mask,
    input  logic                         ref_valid,
    input  logic                         warped_valid,
    input  logic                         last_voxel,
    input  logic [$clog2(DEPTH+1)-1:0]   q_count,
    output logic                         q_push,
    output logic [REC_W-1:0]             q_data
);
    localparam int CNT_W = COUNT_BITS + 1;
    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int SQ_W  = 2*SAMPLE_BITS + COUNT_BITS + 1;
    localparam int QC_W  = $clog2(DEPTH+1);

    // product stage
    logic                            p_valid_reg;
    logic                            p_active_reg;
    logic                            p_last_reg;
    logic signed [SAMPLE_BITS-1:0]   p_x_reg;
    logic signed [SAMPLE_BITS-1:0]   p_y_reg;
    logic signed [2*SAMPLE_BITS-1:0] p_xx_reg;
    logic signed [2*SAMPLE_BITS-1:0] p_yy_reg;
    logic signed [2*SAMPLE_BITS-1:0] p_xy_reg;

    // accumulators
    logic [CNT_W-1:0]        n_reg,   n_next;
    logic signed [SUM_W-1:0] sx_reg,  sx_next;
    logic signed [SUM_W-1:0] sy_reg,  sy_next;
    logic signed [SQ_W-1:0]  sxx_reg, sxx_next;
    logic signed [SQ_W-1:0]  syy_reg, syy_next;
    logic signed [SQ_W-1:0]  sxy_reg, sxy_next;

    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] y_in;
    logic                          accept;
    logic                          take;
    logic [QC_W:0]                 pending;

    assign x_in = $signed(ref_sample[SAMPLE_BITS-1:0]);
    assign y_in = $signed(warped_sample[SAMPLE_BITS-1:0]);

    // a last item in the product stage still owes the queue one record
    assign pending  = (QC_W+1)'(q_count) + (QC_W+1)'(p_valid_reg && p_last_reg);
    assign s_tready = (pending < (QC_W+1)'(DEPTH));
    assign accept   = s_tvalid && s_tready;

    // sums saturate by ignoring pairs once the count is full
    assign take = p_valid_reg && p_active_reg && !n_reg[COUNT_BITS];

    always_comb
    begin
        n_next   = n_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxx_next = sxx_reg;
        syy_next = syy_reg;
        sxy_next = sxy_reg;
        if (take)
        begin
            n_next   = n_reg + 1'b1;
            sx_next  = sx_reg  + SUM_W'(p_x_reg);
            sy_next  = sy_reg  + SUM_W'(p_y_reg);
            sxx_next = sxx_reg + SQ_W'(p_xx_reg);
            syy_next = syy_reg + SQ_W'(p_yy_reg);
            sxy_next = sxy_reg + SQ_W'(p_xy_reg);
        end
    end

    assign q_push = p_valid_reg && p_last_reg;
    assign q_data = {n_next, sx_next, sy_next, sxx_next, syy_next, sxy_next};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_x_reg  <= x_in;
            p_y_reg  <= y_in;
            p_xx_reg <= x_in * x_in;
            p_yy_reg <= y_in * y_in;
            p_xy_reg <= x_in * y_in;
            p_active_reg <= in_mask && ref_valid && warped_valid;
            p_last_reg   <= last_voxel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else
        begin
            p_valid_reg <= accept;
            if (q_push)
            begin
                n_reg   <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
                sxy_reg <= '0;
            end
            else
            begin
                n_reg   <= n_next;
                sx_reg  <= sx_next;
                sy_reg  <= sy_next;
                sxx_reg <= sxx_next;
                syy_reg <= syy_next;
                sxy_reg <= sxy_next;
            end
        end
    end

endmodule

/* rtl/core/mncc_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// No package dependencies; shared by all products in mncc_back.
module mncc_mul #(
    parameter int MAG_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_W-1:0]     a,
    input  logic [MAG_W-1:0]     b,
    output logic                 done,
    output logic [2*MAG_W-1:0]   prod
);
    localparam int PROD_W = 2*MAG_W;
    localparam int CW     = $clog2(MAG_W+1);

    logic [PROD_W-1:0] a_reg;
    logic [MAG_W-1:0]  b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [CW-1:0]     cnt_reg;
    logic              run_reg;
    logic              done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PROD_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && run_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(MAG_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* rtl/core/mncc_back.sv */
// Back end: turns one sum record into variances, covariance and the Q1.30
// correlation via a bit-by-bit root search. Uses mncc_pkg and mncc_mul.
module mncc_back #(
    parameter int SAMPLE_BITS = mncc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = mncc_pkg::COUNT_BITS_DEF,
    parameter int REC_W       = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  logic [REC_W-1:0]                q_data,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mncc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [mncc_pkg::STATUS_W-1:0]   m_tuser
);
    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int SQ_W   = 2*SAMPLE_BITS + COUNT_BITS + 1;
    localparam int MAG_W  = 2*SAMPLE_BITS + 2*COUNT_BITS + 2;
    localparam int PROD_W = 2*MAG_W;
    localparam int FRAC   = mncc_pkg::FRAC_BITS;
    localparam int SRCH_W = PROD_W + 2*FRAC + 4;
    localparam int Q_W    = FRAC + 1;
    localparam int K_W    = $clog2(Q_W);
    localparam int NCC_W  = mncc_pkg::NCC_W;
    localparam int ACNT_W = mncc_pkg::ACNT_W;
    localparam int PAD_W  = mncc_pkg::OUT_DATA_W - NCC_W - ACNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_NXX, S_SXX, S_NYY, S_SYY, S_CHK, S_NXY, S_SXY,
        S_COVABS, S_COV2, S_VV, S_SRCH_ADD, S_SRCH_CMP, S_FINISH
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0]        n_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg;

    logic signed [PROD_W:0]  vx_reg, vy_reg, cov_reg;
    logic                    neg_reg;

    logic [SRCH_W-1:0]       t_reg, s_reg, r_reg, pk_reg, trial_reg;
    logic [Q_W-1:0]          q_reg;
    logic [K_W-1:0]          k_reg;
    logic [1:0]              status_reg;

    logic                    mul_start_reg;
    logic                    mul_start_next;
    logic [MAG_W-1:0]        mul_a_reg, mul_b_reg;
    logic                    mul_done;
    logic [PROD_W-1:0]       mul_prod;

    logic                    out_valid_reg;
    logic [NCC_W-1:0]        out_ncc_reg;
    logic [ACNT_W-1:0]       out_cnt_reg;
    logic [1:0]              out_status_reg;

    logic [SUM_W-1:0]        sx_abs, sy_abs;
    logic [SQ_W-1:0]         sxy_abs;
    logic signed [PROD_W:0]  prod_s;
    logic signed [PROD_W:0]  prod_sxy;
    logic                    out_free;
    logic [NCC_W-1:0]        q_signed;

    mncc_mul #(
        .MAG_W (MAG_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign sx_abs   = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
    assign sy_abs   = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);
    assign sxy_abs  = sxy_reg[SQ_W-1] ? SQ_W'(-sxy_reg) : SQ_W'(sxy_reg);
    assign prod_s   = $signed({1'b0, mul_prod});
    assign prod_sxy = (sx_reg[SUM_W-1] ^ sy_reg[SUM_W-1]) ? -prod_s : prod_s;
    assign out_free = !out_valid_reg || m_tready;
    assign q_signed = neg_reg ? -NCC_W'(q_reg) : NCC_W'(q_reg);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    // launch the next product when the operands are in place
    always_comb
    begin
        case (state_reg)
            S_DISPATCH:                        mul_start_next = (n_reg != '0);
            S_NXX, S_SXX, S_NYY, S_NXY, S_COV2: mul_start_next = mul_done;
            S_CHK:    mul_start_next = (vx_reg != '0) && (vy_reg != '0);
            S_COVABS: mul_start_next = 1'b1;
            default:  mul_start_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            {n_reg, sx_reg, sy_reg, sxx_reg, syy_reg, sxy_reg} <= q_data;
        end
        case (state_reg)
            S_DISPATCH:
            begin
                mul_a_reg <= MAG_W'(n_reg);
                mul_b_reg <= MAG_W'(unsigned'(sxx_reg));
            end
            S_NXX:
            begin
                if (mul_done)
                begin
                    vx_reg    <= prod_s;
                    mul_a_reg <= MAG_W'(sx_abs);
                    mul_b_reg <= MAG_W'(sx_abs);
                end
            end
            S_SXX:
            begin
                if (mul_done)
                begin
                    vx_reg    <= vx_reg - prod_s;
                    mul_a_reg <= MAG_W'(n_reg);
                    mul_b_reg <= MAG_W'(unsigned'(syy_reg));
                end
            end
            S_NYY:
            begin
                if (mul_done)
                begin
                    vy_reg    <= prod_s;
                    mul_a_reg <= MAG_W'(sy_abs);
                    mul_b_reg <= MAG_W'(sy_abs);
                end
            end
            S_SYY:
            begin
                if (mul_done)
                begin
                    vy_reg <= vy_reg - prod_s;
                end
            end
            S_CHK:
            begin
                mul_a_reg <= MAG_W'(n_reg);
                mul_b_reg <= MAG_W'(sxy_abs);
            end
            S_NXY:
            begin
                if (mul_done)
                begin
                    cov_reg   <= sxy_reg[SQ_W-1] ? -prod_s : prod_s;
                    mul_a_reg <= MAG_W'(sx_abs);
                    mul_b_reg <= MAG_W'(sy_abs);
                end
            end
            S_SXY:
            begin
                if (mul_done)
                begin
                    cov_reg <= cov_reg - prod_sxy;
                end
            end
            S_COVABS:
            begin
                neg_reg   <= cov_reg[PROD_W];
                mul_a_reg <= cov_reg[PROD_W] ? MAG_W'(-cov_reg) : MAG_W'(cov_reg);
                mul_b_reg <= cov_reg[PROD_W] ? MAG_W'(-cov_reg) : MAG_W'(cov_reg);
            end
            S_COV2:
            begin
                if (mul_done)
                begin
                    t_reg     <= SRCH_W'(mul_prod) << (2*FRAC);
                    mul_a_reg <= vx_reg[MAG_W-1:0];
                    mul_b_reg <= vy_reg[MAG_W-1:0];
                end
            end
            S_VV:
            begin
                if (mul_done)
                begin
                    // start at bit FRAC: pk = P << 2k, r = (q * P) << (k+1)
                    pk_reg <= SRCH_W'(mul_prod) << (2*FRAC);
                    r_reg  <= '0;
                    s_reg  <= '0;
                    q_reg  <= '0;
                    k_reg  <= K_W'(FRAC);
                end
            end
            S_SRCH_ADD:
            begin
                trial_reg <= s_reg + r_reg + pk_reg;
            end
            S_SRCH_CMP:
            begin
                if (trial_reg <= t_reg)
                begin
                    s_reg        <= trial_reg;
                    r_reg        <= (r_reg >> 1) + pk_reg;
                    q_reg[k_reg] <= 1'b1;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                pk_reg <= pk_reg >> 2;
                k_reg  <= k_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mul_start_reg  <= 1'b0;
            status_reg     <= mncc_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_ncc_reg    <= '0;
            out_cnt_reg    <= '0;
            out_status_reg <= mncc_pkg::ST_OK;
        end
        else
        begin
            mul_start_reg <= mul_start_next;
            if (out_valid_reg && m_tready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (n_reg == '0)
                    begin
                        status_reg <= mncc_pkg::ST_EMPTY;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_NXX;
                    end
                end
                S_NXX:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SXX;
                    end
                end
                S_SXX:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_NYY;
                    end
                end
                S_NYY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SYY;
                    end
                end
                S_SYY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (vx_reg == '0 || vy_reg == '0)
                    begin
                        status_reg <= mncc_pkg::ST_FLAT;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_NXY;
                    end
                end
                S_NXY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SXY;
                    end
                end
                S_SXY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_COVABS;
                    end
                end
                S_COVABS:
                begin
                    state_reg <= S_COV2;
                end
                S_COV2:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_VV;
                    end
                end
                S_VV:
                begin
                    if (mul_done)
                    begin
                        status_reg <= mncc_pkg::ST_OK;
                        state_reg  <= S_SRCH_ADD;
                    end
                end
                S_SRCH_ADD:
                begin
                    state_reg <= S_SRCH_CMP;
                end
                S_SRCH_CMP:
                begin
                    state_reg <= (k_reg == '0) ? S_FINISH : S_SRCH_ADD;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_cnt_reg    <= ACNT_W'(n_reg);
                        out_ncc_reg    <= (status_reg == mncc_pkg::ST_OK) ? q_signed : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_reg, out_ncc_reg};
    assign m_tuser  = out_status_reg;

endmodule

/* rtl/core/masked_normalized_cross_correlation.sv */
// Top level of the masked normalized cross-correlation block.
// Uses mncc_pkg, mncc_front, mncc_queue, mncc_mul and mncc_back.
//
// Input channel (s_*): one voxel pair per transfer. s_tlast marks the last
// voxel of an image. A pair enters the sums when all three s_tuser flags are 1
// and the count has not reached 2^COUNT_BITS.
// Output channel (m_*): one transfer per image, carrying the Pearson
// correlation in Q1.30 (rounded toward zero), the active voxel count and a
// status in m_tuser (ok, no active voxel, zero variance).
// Throughput: one voxel per cycle while s_tready is high; accumulation is a
// two-stage pipeline. After the last voxel, eight products run on one
// bit-serial multiplier, then a root search settles one result bit per
// add/compare step; an empty or constant image finishes early. A two-record
// queue lets the next image stream in while the previous result is computed;
// s_tready drops only when that queue, counting a record still in the product
// stage, is full. A stalled m_tready holds the result register, then the
// queue, then input. Reset clears all sums, the queue and the output valid.
module masked_normalized_cross_correlation #(
    parameter int SAMPLE_BITS = mncc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = mncc_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] ref_sample, [31:16] warped_sample
    input  logic [2:0]  s_tuser,   // [0] in_mask, [1] ref_valid, [2] warped_valid
    input  logic        s_tlast,   // last_voxel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] ncc_value, [56:32] active_count, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);
    localparam int CNT_W = COUNT_BITS + 1;
    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int SQ_W  = 2*SAMPLE_BITS + COUNT_BITS + 1;
    localparam int REC_W = CNT_W + 2*SUM_W + 3*SQ_W;
    localparam int DEPTH = mncc_pkg::QUEUE_DEPTH;
    localparam int FW    = mncc_pkg::FIELD_W;

    logic                       q_push, q_pop, q_empty;
    logic [REC_W-1:0]           q_din, q_dout;
    logic [$clog2(DEPTH+1)-1:0] q_count;

    mncc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .DEPTH       (DEPTH),
        .REC_W       (REC_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .ref_sample    (s_tdata[FW-1:0]),
        .warped_sample (s_tdata[2*FW-1:FW]),
        .in_mask       (s_tuser[0]),
        .ref_valid     (s_tuser[1]),
        .warped_valid  (s_tuser[2]),
        .last_voxel    (s_tlast),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_data        (q_din)
    );

    mncc_queue #(
        .W     (REC_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    mncc_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .REC_W       (REC_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_dout),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != mncc_pkg::ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("nonzero correlation with error status");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824)
                  && ($signed(m_tdata[31:0]) >= -32'sd1073741824))
        else $error("correlation outside Q1.30 range");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[56:32] == '0) == (m_tuser == mncc_pkg::ST_EMPTY)))
        else $error("empty status and count disagree");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < DEPTH) || q_pop)
        else $error("record queue overflow");
`endif

endmodule
